FILE: src/deq_pkg.sv
// Shared types and constants of the double-ended queue unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int FUNC_W     = 3;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_SET_FRONT  = 3'd4,
    FN_SET_BACK   = 3'd5,
    FN_CONTAINS   = 3'd6,
    FN_CLEAR      = 3'd7
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Memory read address select
  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_BACK = 2'd1,
    RD_SCAN = 2'd2
  } rd_sel_t;

  // Memory write address select
  typedef enum logic [1:0] {
    WR_HEAD_DEC = 2'd0,
    WR_TAIL     = 2'd1,
    WR_HEAD     = 2'd2,
    WR_BACK     = 2'd3
  } wr_sel_t;

  typedef enum logic [2:0] {
    PTR_NONE       = 3'd0,
    PTR_PUSH_FRONT = 3'd1,
    PTR_PUSH_BACK  = 3'd2,
    PTR_POP_FRONT  = 3'd3,
    PTR_POP_BACK   = 3'd4,
    PTR_CLEAR      = 3'd5
  } ptr_op_t;

  typedef struct packed {
    logic    load_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    ptr_op_t ptr_op;
    logic    status_load;
    status_t status_code;
    logic    cap_old;
    logic    cap_front;
    logic    scan_clr;
    logic    scan_inc;
    logic    scan_cmp;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

FILE: src/deq_in_if.sv
// Request channel of the double-ended queue unit: valid/ready plus operation fields.
// Depends on deq_pkg.
interface deq_in_if;
  logic                        valid;
  logic                        ready;
  logic [deq_pkg::FUNC_W-1:0]  func;
  logic [deq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

FILE: src/deq_out_if.sv
// Result channel of the double-ended queue unit: valid/ready plus result fields.
// Depends on deq_pkg.
interface deq_out_if;
  logic                         valid;
  logic                         ready;
  logic [deq_pkg::VALUE_W-1:0]  old_value;
  logic                         hit;
  logic [deq_pkg::STATUS_W-1:0] status;
  logic [deq_pkg::COUNT_W-1:0]  count;
  logic [deq_pkg::VALUE_W-1:0]  front_value;
  logic [deq_pkg::VALUE_W-1:0]  back_value;

  modport source (output valid, output old_value, output hit, output status, output count,
                  output front_value, output back_value, input ready);
  modport sink   (input valid, input old_value, input hit, input status, input count,
                  input front_value, input back_value, output ready);
endinterface

FILE: src/deq_ctrl.sv
// Sequencer of the double-ended queue unit: one-hot state machine issuing datapath commands.
// Depends on deq_pkg.
module deq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [deq_pkg::FUNC_W-1:0] req_func,
  output logic                       req_ready,
  input  deq_pkg::stat_t             stat,
  output deq_pkg::cmd_t              cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_POP      = 8'b0000_0100,
    S_SET      = 8'b0000_1000,
    S_SCAN_RD  = 8'b0001_0000,
    S_SCAN_CMP = 8'b0010_0000,
    S_FRONT    = 8'b0100_0000,
    S_BACK     = 8'b1000_0000
  } state_t;

  // done state folded in: S_BACK loops on itself until the result register frees up
  state_t         state, state_next;
  deq_pkg::func_t func, func_next;
  logic           back_rd_done, back_rd_done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      func         <= deq_pkg::FN_PUSH_FRONT;
      back_rd_done <= 1'b0;
    end else begin
      state        <= state_next;
      func         <= func_next;
      back_rd_done <= back_rd_done_next;
    end
  end

  always_comb begin
    cmd               = '0;
    state_next        = state;
    func_next         = func;
    back_rd_done_next = back_rd_done;
    req_ready         = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_in = 1'b1;
          func_next   = deq_pkg::func_t'(req_func);
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FRONT;
        unique case (func)
          deq_pkg::FN_PUSH_FRONT, deq_pkg::FN_PUSH_BACK: begin
            if (stat.full) begin
              cmd.status_load = 1'b1;
              cmd.status_code = deq_pkg::ST_FULL;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = (func == deq_pkg::FN_PUSH_FRONT) ? deq_pkg::WR_HEAD_DEC
                                                             : deq_pkg::WR_TAIL;
              cmd.ptr_op = (func == deq_pkg::FN_PUSH_FRONT) ? deq_pkg::PTR_PUSH_FRONT
                                                             : deq_pkg::PTR_PUSH_BACK;
            end
          end
          deq_pkg::FN_POP_FRONT, deq_pkg::FN_POP_BACK: begin
            if (stat.empty) begin
              cmd.status_load = 1'b1;
              cmd.status_code = deq_pkg::ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = (func == deq_pkg::FN_POP_FRONT) ? deq_pkg::RD_HEAD
                                                            : deq_pkg::RD_BACK;
              state_next = S_POP;
            end
          end
          deq_pkg::FN_SET_FRONT, deq_pkg::FN_SET_BACK: begin
            if (stat.empty) begin
              // replace on empty queue is a push at that end
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = (func == deq_pkg::FN_SET_FRONT) ? deq_pkg::WR_HEAD_DEC
                                                            : deq_pkg::WR_TAIL;
              cmd.ptr_op = (func == deq_pkg::FN_SET_FRONT) ? deq_pkg::PTR_PUSH_FRONT
                                                            : deq_pkg::PTR_PUSH_BACK;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = (func == deq_pkg::FN_SET_FRONT) ? deq_pkg::RD_HEAD
                                                            : deq_pkg::RD_BACK;
              state_next = S_SET;
            end
          end
          deq_pkg::FN_CONTAINS: begin
            cmd.scan_clr = 1'b1;
            if (!stat.empty) begin
              state_next = S_SCAN_RD;
            end
          end
          deq_pkg::FN_CLEAR: begin
            cmd.ptr_op = deq_pkg::PTR_CLEAR;
          end
          default: ;
        endcase
      end
      S_POP: begin
        cmd.cap_old = 1'b1;
        cmd.ptr_op  = (func == deq_pkg::FN_POP_FRONT) ? deq_pkg::PTR_POP_FRONT
                                                       : deq_pkg::PTR_POP_BACK;
        state_next  = S_FRONT;
      end
      S_SET: begin
        cmd.cap_old = 1'b1;
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = (func == deq_pkg::FN_SET_FRONT) ? deq_pkg::WR_HEAD : deq_pkg::WR_BACK;
        state_next  = S_FRONT;
      end
      S_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = deq_pkg::RD_SCAN;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        cmd.scan_inc = 1'b1;
        state_next   = (stat.match || stat.scan_last) ? S_FRONT : S_SCAN_RD;
      end
      S_FRONT: begin
        cmd.rd_en         = 1'b1;
        cmd.rd_sel        = deq_pkg::RD_HEAD;
        back_rd_done_next = 1'b0;
        state_next        = S_BACK;
      end
      S_BACK: begin
        if (!back_rd_done) begin
          // front word arrives now; launch the back read
          cmd.cap_front     = 1'b1;
          cmd.rd_en         = 1'b1;
          cmd.rd_sel        = deq_pkg::RD_BACK;
          back_rd_done_next = 1'b1;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: src/deq_dp.sv
// Datapath of the double-ended queue unit: ring memory, head and fill registers,
// scan index, result fields and the output register. Depends on deq_pkg and deq_out_if.
module deq_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [deq_pkg::VALUE_W-1:0] req_value,
  input  deq_pkg::cmd_t               cmd,
  output deq_pkg::stat_t              stat,
  deq_out_if.source                   rsp
);

  logic [deq_pkg::DATA_WIDTH-1:0] mem [deq_pkg::DEPTH];
  logic [deq_pkg::DATA_WIDTH-1:0] rdata;
  logic [deq_pkg::DATA_WIDTH-1:0] data;
  logic [deq_pkg::DATA_WIDTH-1:0] old_word;
  logic [deq_pkg::DATA_WIDTH-1:0] front_word;
  logic                           hit;
  deq_pkg::status_t               status;

  logic [deq_pkg::ADDR_W-1:0] head, head_next;
  logic [deq_pkg::CNT_W-1:0]  held, held_next;
  logic [deq_pkg::ADDR_W-1:0] idx;

  logic [deq_pkg::ADDR_W-1:0] head_dec, head_inc, tail_pos, back_pos, scan_pos;
  logic [deq_pkg::ADDR_W-1:0] rd_addr, wr_addr;

  // (base + offset) mod DEPTH, offset at most DEPTH
  function automatic logic [deq_pkg::ADDR_W-1:0] ring_add(
    input logic [deq_pkg::ADDR_W-1:0] base,
    input logic [deq_pkg::CNT_W-1:0]  offset
  );
    logic [deq_pkg::SUM_W-1:0] sum;
    sum = deq_pkg::SUM_W'(base) + deq_pkg::SUM_W'(offset);
    if (sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH)) begin
      sum = sum - deq_pkg::SUM_W'(deq_pkg::DEPTH);
    end
    return sum[deq_pkg::ADDR_W-1:0];
  endfunction

  assign head_dec = (head == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1) : head - 1'b1;
  assign head_inc = (head == deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_pos = ring_add(head, held);
  assign back_pos = ring_add(head, (held == '0) ? '0 : held - 1'b1);
  assign scan_pos = ring_add(head, deq_pkg::CNT_W'(idx));

  always_comb begin
    unique case (cmd.rd_sel)
      deq_pkg::RD_HEAD: rd_addr = head;
      deq_pkg::RD_BACK: rd_addr = back_pos;
      deq_pkg::RD_SCAN: rd_addr = scan_pos;
      default:          rd_addr = head;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      deq_pkg::WR_HEAD_DEC: wr_addr = head_dec;
      deq_pkg::WR_TAIL:     wr_addr = tail_pos;
      deq_pkg::WR_HEAD:     wr_addr = head;
      deq_pkg::WR_BACK:     wr_addr = back_pos;
      default:              wr_addr = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    head_next = head;
    held_next = held;
    unique case (cmd.ptr_op)
      deq_pkg::PTR_PUSH_FRONT: begin
        head_next = head_dec;
        held_next = held + 1'b1;
      end
      deq_pkg::PTR_PUSH_BACK: begin
        held_next = held + 1'b1;
      end
      deq_pkg::PTR_POP_FRONT: begin
        head_next = (held == deq_pkg::CNT_W'(1)) ? '0 : head_inc;
        held_next = held - 1'b1;
      end
      deq_pkg::PTR_POP_BACK: begin
        head_next = (held == deq_pkg::CNT_W'(1)) ? '0 : head;
        held_next = held - 1'b1;
      end
      deq_pkg::PTR_CLEAR: begin
        head_next = '0;
        held_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      held <= '0;
    end else begin
      head <= head_next;
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      data     <= req_value[deq_pkg::DATA_WIDTH-1:0];
      old_word <= '0;
      hit      <= 1'b0;
      status   <= deq_pkg::ST_OK;
    end
    if (cmd.status_load) begin
      status <= cmd.status_code;
    end
    if (cmd.cap_old) begin
      old_word <= rdata;
    end
    if (cmd.cap_front) begin
      front_word <= (held == '0) ? '0 : rdata;
    end
    if (cmd.scan_cmp && stat.match) begin
      hit <= 1'b1;
    end
    if (cmd.scan_clr) begin
      idx <= '0;
    end else if (cmd.scan_inc) begin
      idx <= idx + 1'b1;
    end
  end

  assign stat.empty     = (held == '0);
  assign stat.full      = (held >= deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign stat.match     = (rdata == data);
  assign stat.scan_last = (deq_pkg::CNT_W'(idx) == held - 1'b1);
  assign stat.out_free  = !rsp.valid || rsp.ready;

  // result register; a finished result waits here while the next request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.old_value   <= deq_pkg::VALUE_W'(old_word);
      rsp.hit         <= hit;
      rsp.status      <= status;
      rsp.count       <= deq_pkg::COUNT_W'(held);
      rsp.front_value <= deq_pkg::VALUE_W'(front_word);
      rsp.back_value  <= (held == '0) ? '0 : deq_pkg::VALUE_W'(rdata);
    end
  end

endmodule

FILE: src/double_ended_queue_unit.sv
// Double-ended queue over a 16-entry ring memory with one write and one registered read port.
// Contains reads and compares entries from the front one at a time, up to a match or the back.
// The single memory read port serialises the work: old word, new front and new back are read in turn.
// A new request is taken in the cycle after the result is loaded, while that result waits.
// Synchronous active-high rst empties the queue; memory contents are not cleared.
module double_ended_queue_unit (
  input  logic      clk,
  input  logic      rst,
  deq_in_if.sink    req,
  deq_out_if.source rsp
);

  deq_pkg::cmd_t  cmd;
  deq_pkg::stat_t stat;
  logic           req_ready;

  assign req.ready = req_ready;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  deq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_value (req.value),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule

FILE: bench/deque_model_checker.sv
`timescale 1ns / 100ps
// Result checker for the double-ended queue unit: keeps its own copy of the ring,
// predicts one result per accepted request and compares it with the result channel.
// Depends on deq_pkg, deq_in_if and deq_out_if.
module deque_model_checker
  import deq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  deq_in_if    req,
  deq_out_if   rsp,
  output int   errors,
  output int   pending,
  output int   results_seen,
  output int   full_drops,
  output int   empty_pops,
  output int   search_hits
);

  typedef struct packed {
    logic [VALUE_W-1:0] old_value;
    logic               hit;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic [VALUE_W-1:0] front_value;
    logic [VALUE_W-1:0] back_value;
  } deque_result_t;

  logic [VALUE_W-1:0] ring [DEPTH];
  logic [ADDR_W-1:0]  head;
  logic [CNT_W-1:0]   held;
  deque_result_t      expected_q [$];
  int err_cnt, seen_cnt, drop_cnt, empty_cnt, hit_cnt;

  function automatic logic [ADDR_W-1:0] back_slot();
    return (held == 0) ? head : head + ADDR_W'(held - 1'b1);
  endfunction

  function automatic void push_at_front(logic [VALUE_W-1:0] v);
    head       = head - 1'b1;
    ring[head] = v;
    held       = held + 1'b1;
  endfunction

  function automatic void push_at_back(logic [VALUE_W-1:0] v);
    ring[head + ADDR_W'(held)] = v;
    held                       = held + 1'b1;
  endfunction

  // Applies one operation to the shadow ring and returns the result it should produce.
  function automatic deque_result_t apply_deque_op(func_t f, logic [VALUE_W-1:0] v);
    deque_result_t     r;
    logic [ADDR_W-1:0] slot;
    r        = '0;
    r.status = ST_OK;
    case (f)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (held == CNT_W'(DEPTH)) r.status = ST_FULL;
        else if (f == FN_PUSH_FRONT) push_at_front(v);
        else push_at_back(v);
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (f == FN_POP_FRONT) begin
            r.old_value = ring[head];
            head        = head + 1'b1;
          end else begin
            r.old_value = ring[back_slot()];
          end
          held = held - 1'b1;
          if (held == 0) head = '0;  // emptied queue restarts at slot zero
        end
      end
      FN_SET_FRONT: begin
        if (held == 0) begin
          push_at_front(v);
        end else begin
          r.old_value = ring[head];
          ring[head]  = v;
        end
      end
      FN_SET_BACK: begin
        if (held == 0) begin
          push_at_back(v);
        end else begin
          slot        = back_slot();
          r.old_value = ring[slot];
          ring[slot]  = v;
        end
      end
      FN_CONTAINS: begin
        for (int i = 0; i < DEPTH; i++)
          if (i < held && ring[head + ADDR_W'(i)] == v) r.hit = 1'b1;
      end
      default: begin
        held = '0;
        head = '0;
      end
    endcase
    r.count = COUNT_W'(held);
    if (held != 0) begin
      r.front_value = ring[head];
      r.back_value  = ring[back_slot()];
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("%0t: result %0d, %s mismatch: expected %h, got %h",
                 $time, seen_cnt, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    deque_result_t want;
    deque_result_t got;
    if (rst) begin
      head = '0;
      held = '0;
      expected_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.old_value   = rsp.old_value;
        got.hit         = rsp.hit;
        got.status      = status_t'(rsp.status);
        got.count       = rsp.count;
        got.front_value = rsp.front_value;
        got.back_value  = rsp.back_value;
        seen_cnt++;
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("%0t: result transfer with no request outstanding", $time);
        end else begin
          want = expected_q.pop_front();
          if (want.status == ST_FULL) drop_cnt++;
          if (want.status == ST_EMPTY) empty_cnt++;
          if (want.hit) hit_cnt++;
          check_field("old_value", want.old_value, got.old_value);
          check_field("hit", VALUE_W'(want.hit), VALUE_W'(got.hit));
          check_field("status", VALUE_W'(want.status), VALUE_W'(got.status));
          check_field("count", VALUE_W'(want.count), VALUE_W'(got.count));
          check_field("front_value", want.front_value, got.front_value);
          check_field("back_value", want.back_value, got.back_value);
        end
      end
      if (req.valid && req.ready)
        expected_q.push_back(apply_deque_op(func_t'(req.func), req.value));
    end
    pending      <= expected_q.size();
    errors       <= err_cnt;
    results_seen <= seen_cnt;
    full_drops   <= drop_cnt;
    empty_pops   <= empty_cnt;
    search_hits  <= hit_cnt;
  end

endmodule

FILE: bench/double_ended_queue_unit_tb.sv
`timescale 1ns / 100ps
// Top of the double-ended queue unit testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on deq_pkg, the channel interfaces,
// deque_model_checker and double_ended_queue_unit.
module double_ended_queue_unit_tb;
  import deq_pkg::*;

  logic clk;
  logic rst;

  deq_in_if  req ();
  deq_out_if rsp ();

  int errors, pending, results_seen, full_drops, empty_pops, search_hits;
  int tx_idle_pct;
  int rx_idle_pct;
  int op_tally [8];
  logic [VALUE_W-1:0] recent [8];
  int recent_wr;

  // Operation mix per traffic mode: fill, drain, mixed. Order follows func_t.
  int mode_weights [3][8] = '{'{35, 35, 8, 8, 4, 4, 5, 1},
                              '{10, 10, 30, 30, 5, 5, 8, 2},
                              '{15, 15, 15, 15, 10, 10, 15, 5}};

  double_ended_queue_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  deque_model_checker model_check (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .rsp          (rsp),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .full_drops   (full_drops),
    .empty_pops   (empty_pops),
    .search_hits  (search_hits)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("** double_ended_queue_unit: FAILED **");
    $finish;
  end

  // One request transfer, preceded by random idle cycles on the sender side.
  task automatic send_op(input func_t f, input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func  <= f;
    req.value <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    op_tally[f]++;
    if (f != FN_POP_FRONT && f != FN_POP_BACK && f != FN_CONTAINS && f != FN_CLEAR) begin
      recent[recent_wr] = v;
      recent_wr         = (recent_wr + 1) % 8;
    end
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_random(input int n, input int tx_pct, input int rx_pct);
    int mode;
    int pick;
    int acc;
    func_t f;
    logic [VALUE_W-1:0] v;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    mode = 0;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 5) mode = $urandom_range(2);
      pick = $urandom_range(99);
      acc  = 0;
      f    = FN_CLEAR;
      for (int j = 0; j < 8; j++) begin
        acc += mode_weights[mode][j];
        if (pick < acc) begin
          f = func_t'(j);
          break;
        end
      end
      case ($urandom_range(9))
        4, 5:    v = recent[$urandom_range(7)];  // repeats give contains its hits
        6:       v = VALUE_W'($urandom_range(3));
        7: begin
          case ($urandom_range(2))
            0:       v = '0;
            1:       v = '1;
            default: v = {1'b1, {(VALUE_W-1){1'b0}}};
          endcase
        end
        default: v = $urandom;
      endcase
      send_op(f, v);
      if ($urandom_range(199) == 0) drain_results();
    end
  endtask

  initial begin
    rst         = 1'b1;
    req.valid   = 1'b0;
    req.func    = FN_PUSH_FRONT;
    req.value   = '0;
    tx_idle_pct = 29;
    rx_idle_pct = 66;
    recent_wr   = 0;
    for (int i = 0; i < 8; i++) recent[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty-queue corner cases, then replace on one entry
    send_op(FN_POP_FRONT, '0);
    send_op(FN_POP_BACK, '1);
    send_op(FN_CONTAINS, '0);
    send_op(FN_CLEAR, '0);
    send_op(FN_SET_BACK, 32'hFFFF_FFFF);
    send_op(FN_SET_FRONT, 32'h0000_0000);
    send_op(FN_POP_BACK, '0);
    send_op(FN_SET_FRONT, 32'hA5A5_A5A5);
    send_op(FN_SET_BACK, 32'h5A5A_5A5A);
    // Fill from both ends so the ring wraps, then overflow
    for (int i = 0; i < 15; i++)
      send_op((i % 2) ? FN_PUSH_FRONT : FN_PUSH_BACK,
              (i == 0) ? 32'h8000_0000 : (i == 1) ? 32'h0000_0001 : 32'($urandom));
    send_op(FN_PUSH_BACK, 32'h1234_5678);
    send_op(FN_CONTAINS, 32'h5A5A_5A5A);
    send_op(FN_POP_FRONT, '0);
    send_op(FN_CLEAR, '0);
    drain_results();

    run_random(650, 29, 66);
    drain_results();
    run_random(650, 66, 29);
    drain_results();
    run_random(625, 0, 0);
    drain_results();
    repeat (4 + 2 * DEPTH + 8) @(posedge clk);

    $display("Issued push %0d/%0d, pop %0d/%0d, set %0d/%0d, contains %0d, clear %0d",
             op_tally[FN_PUSH_FRONT], op_tally[FN_PUSH_BACK], op_tally[FN_POP_FRONT],
             op_tally[FN_POP_BACK], op_tally[FN_SET_FRONT], op_tally[FN_SET_BACK],
             op_tally[FN_CONTAINS], op_tally[FN_CLEAR]);
    $display("Checked %0d results: %0d pushes dropped when full, %0d pops from empty, %0d hits",
             results_seen, full_drops, empty_pops, search_hits);
    if (errors == 0 && pending == 0) begin
      $display("** double_ended_queue_unit: PASSED **");
    end else begin
      $display("** double_ended_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
